// ===== hw/rtl/rfct_pkg.sv =====
package rfct_pkg;

    localparam int CountW = 11;

    localparam logic MODE_FLIP = 1'b0;
    localparam logic MODE_COUNT = 1'b1;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_POP    = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_VISIT  = 7'b0010000,
        ST_CHILD  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } rfct_state_t;

    typedef struct packed {
        logic mode;
        logic [CountW-1:0] range_low;
        logic [CountW-1:0] range_high;
    } rfct_req_t;

endpackage

// ===== hw/rtl/rfct_if.sv =====
interface rfct_if #(
    parameter int W = 1
);
    logic valid;
    logic ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rfct_ram.sv =====
module rfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/rfct_engine.sv =====
module rfct_engine
    import rfct_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CountW-1:0] cfg_size,
    input  logic              start,
    input  rfct_req_t         req,
    output logic              busy,
    output logic              done,
    output logic              done_is_count,
    output logic [CountW-1:0] total
);
    localparam int NW = $clog2(MAX_ELEMENTS) + 1;
    localparam int NODES = 2 * (1 << (NW - 1));
    localparam int AW = $clog2(NODES);
    localparam int MW = NW + 1;
    localparam int DEP = 2 * (NW + 1);

    typedef struct packed {
        logic [AW-1:0] idx;
        logic [NW-1:0] lo;
        logic [NW-1:0] hi;
        logic          post;
    } frame_t;

    rfct_state_t state_reg, state_next;
    frame_t stk_reg [DEP];
    logic [$clog2(DEP+1)-1:0] sp_reg;
    frame_t cur_reg;
    logic [NW-1:0] size_reg, a_reg, b_reg;
    logic mode_reg;
    logic [CountW-1:0] total_reg;
    logic [AW-1:0] clr_reg;
    logic [1:0] ph_reg;
    logic [MW-1:0] node_reg, lc_reg;
    logic inv_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [MW:0] wdata, rdata;

    rfct_ram #(.WIDTH(MW + 1), .DEPTH(NODES)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [NW-1:0] mid, cl, ch;
    assign mid = cur_reg.lo + ((cur_reg.hi - cur_reg.lo) >> 1);
    assign cl = (32'(req.range_low) > 32'(size_reg)) ? size_reg
              : NW'(req.range_low);
    assign ch = (32'(req.range_high) > 32'(size_reg)) ? size_reg
              : NW'(req.range_high);

    logic [MW-1:0] span_c;
    assign span_c = MW'(cur_reg.hi - cur_reg.lo);

    assign busy = (state_reg != ST_IDLE);
    assign total = total_reg;
    assign done_is_count = (mode_reg == MODE_COUNT);

    // Visit: ST_READ reads node; ST_VISIT has node data; children handled in ST_CHILD
    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = cur_reg.idx;
        wdata = '0;
        raddr = cur_reg.idx;
        done = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                if (clr_reg == AW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (cl < ch) ? ST_READ : ST_DONE;
                end
            end
            ST_POP:
            begin
                state_next = (sp_reg == 0) ? ST_DONE : ST_READ;
            end
            ST_READ:
            begin
                raddr = cur_reg.post ? (cur_reg.idx << 1) : cur_reg.idx;
                state_next = ST_VISIT;
            end
            ST_VISIT:
            begin
                if (cur_reg.post)
                begin
                    raddr = (cur_reg.idx << 1) | AW'(1);
                    state_next = ST_CHILD;
                end
                else if (b_reg <= cur_reg.lo || cur_reg.hi <= a_reg)
                begin
                    state_next = ST_POP;
                end
                else if (a_reg <= cur_reg.lo && cur_reg.hi <= b_reg)
                begin
                    if (mode_reg == MODE_FLIP)
                    begin
                        we = 1'b1;
                        wdata = {~rdata[MW], span_c - rdata[MW-1:0]};
                    end
                    state_next = ST_POP;
                end
                else if (span_c < MW'(2))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    raddr = cur_reg.idx << 1;
                    state_next = ST_CHILD;
                end
            end
            ST_CHILD:
            begin
                if (cur_reg.post)
                begin
                    we = 1'b1;
                    wdata = {1'b0, lc_reg + rdata[MW-1:0]};
                    state_next = ST_POP;
                end
                else if (ph_reg == 2'd0)
                begin
                    raddr = (cur_reg.idx << 1) | AW'(1);
                    if (inv_reg)
                    begin
                        we = 1'b1;
                        waddr = cur_reg.idx << 1;
                        wdata = {~rdata[MW], MW'(mid - cur_reg.lo) - rdata[MW-1:0]};
                    end
                end
                else if (ph_reg == 2'd1)
                begin
                    if (inv_reg)
                    begin
                        we = 1'b1;
                        waddr = (cur_reg.idx << 1) | AW'(1);
                        wdata = {~rdata[MW], MW'(cur_reg.hi - mid) - rdata[MW-1:0]};
                    end
                end
                else
                begin
                    we = 1'b1;
                    wdata = {1'b0, node_reg};
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            sp_reg <= '0;
            size_reg <= NW'(MAX_ELEMENTS);
            ph_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                clr_reg <= '0;
                if (cfg_size == '0)
                begin
                    size_reg <= NW'(1);
                end
                else if ({{(32-CountW){1'b0}}, cfg_size} > 32'(MAX_ELEMENTS))
                begin
                    size_reg <= NW'(MAX_ELEMENTS);
                end
                else
                begin
                    size_reg <= NW'(cfg_size);
                end
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        sp_reg <= '0;
                        cur_reg <= '{idx: AW'(1), lo: '0, hi: size_reg, post: 1'b0};
                        a_reg <= cl;
                        b_reg <= ch;
                        mode_reg <= req.mode;
                        total_reg <= '0;
                    end
                end
                ST_POP:
                begin
                    if (sp_reg != 0)
                    begin
                        cur_reg <= stk_reg[sp_reg - 1'b1];
                        sp_reg <= sp_reg - 1'b1;
                    end
                end
                ST_VISIT:
                begin
                    node_reg <= rdata[MW-1:0];
                    inv_reg <= rdata[MW];
                    ph_reg <= '0;
                    if (!cur_reg.post && mode_reg == MODE_COUNT
                        && a_reg <= cur_reg.lo && cur_reg.hi <= b_reg
                        && !(b_reg <= cur_reg.lo || cur_reg.hi <= a_reg))
                    begin
                        total_reg <= total_reg + CountW'(rdata[MW-1:0]);
                    end
                end
                ST_CHILD:
                begin
                    if (cur_reg.post)
                    begin
                        ph_reg <= '0;
                    end
                    else if (ph_reg == 2'd0)
                    begin
                        ph_reg <= 2'd1;
                    end
                    else if (ph_reg == 2'd1)
                    begin
                        ph_reg <= 2'd2;
                    end
                    else
                    begin
                        // push post (flip only), right; visit left now
                        if (mode_reg == MODE_COUNT)
                        begin
                            stk_reg[sp_reg] <= '{idx: (cur_reg.idx << 1) | AW'(1),
                                                lo: mid, hi: cur_reg.hi, post: 1'b0};
                            sp_reg <= sp_reg + 1'b1;
                        end
                        else
                        begin
                            stk_reg[sp_reg] <= '{idx: cur_reg.idx, lo: cur_reg.lo,
                                                hi: cur_reg.hi, post: 1'b1};
                            stk_reg[sp_reg + 1'b1] <= '{idx: (cur_reg.idx << 1) | AW'(1),
                                                       lo: mid, hi: cur_reg.hi, post: 1'b0};
                            sp_reg <= sp_reg + 2'd2;
                        end
                        cur_reg <= '{idx: cur_reg.idx << 1, lo: cur_reg.lo, hi: mid,
                                     post: 1'b0};
                    end
                end
                default:
                begin
                end
            endcase
            if (state_reg == ST_VISIT && cur_reg.post)
            begin
                lc_reg <= rdata[MW-1:0];
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done)) else $error("double done");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done) else $error("done in clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= DEP) else $error("stack overflow");
endmodule

// ===== hw/rtl/range_flip_count_ones_tree.sv =====
// channel  dir  payload
// in       sink mode, range_low, range_high
// out      src  ones_count
// cfg      in   cfg_we, cfg_data (size_in_use)
// Each item walks the tree depth first: read and visit per node, then pop or split;
// a split node passes ST_CHILD phases 0 to 2 to push its flag down; a flip re-sums it
// in a post frame: read, visit, child, pop. An empty range goes straight to done.
// Reset or a size write starts a clearing pass over all 2*2^ceil(log2 MAX_ELEMENTS) nodes.
// A finished count waits in the output register; in_ready needs it empty.
module range_flip_count_ones_tree
    import rfct_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CountW-1:0] cfg_data,
    rfct_if.sink              in_ch,
    rfct_if.source            out_ch
);
    logic busy, done, done_cnt, start;
    logic [CountW-1:0] total;
    logic out_valid_reg;
    logic [CountW-1:0] out_data_reg;

    assign in_ch.ready = !busy && !out_valid_reg;
    assign start = in_ch.valid && in_ch.ready;

    rfct_engine #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_size(cfg_data),
        .start(start), .req(rfct_req_t'(in_ch.data)), .busy(busy), .done(done),
        .done_is_count(done_cnt), .total(total)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && done_cnt)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg <= total;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;
endmodule
